// ===== rtl/jdp_pkg.sv =====
// shared types, constants and tables for the joystick polar drive block
package jdp_pkg;

  localparam int AXIS_LIMIT_DEFAULT = 32767;
  localparam int PCT_MAX = 100;
  localparam int CAM_LIMIT = 90;
  localparam int CAM_STEP = 5;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] MODE_AXIS = 2'd0;
  localparam logic [1:0] MODE_BUTTON = 2'd1;

  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         event_number;
    logic signed [15:0] event_value;
  } in_item_t;

  typedef struct packed {
    logic [6:0]        speed_pct;
    logic [8:0]        heading_deg;
    logic [6:0]        brake_pct;
    logic signed [7:0] pan_deg;
    logic signed [7:0] tilt_deg;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_AXIS_X, OP_AXIS_Y, OP_BRAKE, OP_PAN, OP_TILT, OP_STOP
  } op_t;

  // classified request handed from front to back
  typedef struct packed {
    op_t                op;
    logic signed [16:0] value;
    logic [14:0]        divisor;
    logic               div_neg;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_PCT, ST_SQRT, ST_HEAD, ST_OCT, ST_FIN, ST_OUT
  } state_t;

  // tan(d) scaled by 1e10, d = 1..44
  function automatic logic [33:0] tan_entry(input logic [5:0] d);
    logic [33:0] t;
    case (d)
      6'd1: t = 34'd174550649;   6'd2: t = 34'd349207695;
      6'd3: t = 34'd524077793;   6'd4: t = 34'd699268119;
      6'd5: t = 34'd874886635;   6'd6: t = 34'd1051042353;
      6'd7: t = 34'd1227845609;  6'd8: t = 34'd1405408347;
      6'd9: t = 34'd1583844403;  6'd10: t = 34'd1763269807;
      6'd11: t = 34'd1943803091; 6'd12: t = 34'd2125565617;
      6'd13: t = 34'd2308681911; 6'd14: t = 34'd2493280028;
      6'd15: t = 34'd2679491924; 6'd16: t = 34'd2867453858;
      6'd17: t = 34'd3057306815; 6'd18: t = 34'd3249196962;
      6'd19: t = 34'd3443276133; 6'd20: t = 34'd3639702343;
      6'd21: t = 34'd3838640350; 6'd22: t = 34'd4040262258;
      6'd23: t = 34'd4244748162; 6'd24: t = 34'd4452286853;
      6'd25: t = 34'd4663076582; 6'd26: t = 34'd4877325886;
      6'd27: t = 34'd5095254495; 6'd28: t = 34'd5317094317;
      6'd29: t = 34'd5543090515; 6'd30: t = 34'd5773502692;
      6'd31: t = 34'd6008606190; 6'd32: t = 34'd6248693519;
      6'd33: t = 34'd6494075932; 6'd34: t = 34'd6745085168;
      6'd35: t = 34'd7002075382; 6'd36: t = 34'd7265425280;
      6'd37: t = 34'd7535540501; 6'd38: t = 34'd7812856265;
      6'd39: t = 34'd8097840332; 6'd40: t = 34'd8390996312;
      6'd41: t = 34'd8692867378; 6'd42: t = 34'd9004040443;
      6'd43: t = 34'd9325150861; 6'd44: t = 34'd9656887748;
      default: t = '1;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/joystick_deadzone_polar_drive.sv =====
// top level of the joystick dead-zone polar drive block
//  channel  | signals                        | direction
//  events   | in_valid in_stall in_data      | in
//  results  | out_valid out_stall out_data   | out
//  config   | cfg_valid cfg_ready cfg_data   | in
// the back end sends camera, button and ignored requests straight to its output
// state; brake is worked out in its divide state, and stick axes pass a restoring divider,
// a square root search and octant table compares; a result register holds the output
// rst is synchronous; the state machine, the queue, the held drive values and the dead zone clear to zero
// the front keeps taking events into a QUEUE_DEPTH-entry queue (two by default) while results stall, until it is full
module joystick_deadzone_polar_drive #(
  parameter int AXIS_LIMIT = jdp_pkg::AXIS_LIMIT_DEFAULT,
  parameter int QUEUE_DEPTH = jdp_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  jdp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output jdp_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [14:0]        cfg_data
);
  logic [14:0]   deadzone;
  jdp_pkg::cmd_t front_cmd, q_cmd;
  logic          q_full, q_valid, q_pop;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) deadzone <= '0;
    else if (cfg_valid) deadzone <= cfg_data;
  end

  assign in_stall = q_full;

  jdp_front #(.AXIS_LIMIT(AXIS_LIMIT)) u_front (
    .deadzone(deadzone), .item(in_data), .cmd(front_cmd)
  );

  jdp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst), .push(in_valid), .push_data(front_cmd), .full(q_full),
    .pop(q_pop), .not_empty(q_valid), .pop_data(q_cmd)
  );

  jdp_back u_back (
    .clk(clk), .rst(rst), .cmd_valid(q_valid), .cmd(q_cmd), .cmd_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_data)
  );
endmodule

// ===== rtl/jdp_front.sv =====
// front end: dead zone, divisor and event classification
module jdp_front #(
  parameter int AXIS_LIMIT = jdp_pkg::AXIS_LIMIT_DEFAULT
) (
  input  logic [14:0]      deadzone,
  input  jdp_pkg::in_item_t item,
  output jdp_pkg::cmd_t    cmd
);
  logic signed [16:0] v;
  logic signed [16:0] dz;
  logic signed [16:0] vdz;
  logic [15:0]        span;
  logic [31:0]        dprod;
  logic [15:0]        dv;

  // divisor magnitude; sign travels with the request
  assign span = (AXIS_LIMIT[15:0] >= {1'b0, deadzone}) ?
                (AXIS_LIMIT[15:0] - {1'b0, deadzone}) :
                ({1'b0, deadzone} - AXIS_LIMIT[15:0]);
  // span / 100 by reciprocal, exact for span below 2^15
  assign dprod = {16'd0, span} * 32'd41944;
  assign dv = {6'd0, dprod[31:22]};

  always_comb begin
    v = 17'(item.event_value);
    dz = {2'b00, deadzone};
    if (v <= dz && v >= -dz) vdz = '0;
    else if (v > dz) vdz = v - dz;
    else vdz = v + dz;
    cmd.op = jdp_pkg::OP_NONE;
    cmd.value = v;
    cmd.divisor = dv[14:0];
    cmd.div_neg = 1'b0;
    case (item.mode)
      jdp_pkg::MODE_AXIS: begin
        case (item.event_number)
          8'd0: begin
            cmd.op = jdp_pkg::OP_AXIS_X; cmd.value = vdz;
            cmd.div_neg = ({1'b0, deadzone} > AXIS_LIMIT[15:0]);
          end
          8'd1: begin
            cmd.op = jdp_pkg::OP_AXIS_Y; cmd.value = vdz;
            cmd.div_neg = ({1'b0, deadzone} < AXIS_LIMIT[15:0]);
          end
          8'd2: cmd.op = jdp_pkg::OP_BRAKE;
          8'd6: cmd.op = jdp_pkg::OP_PAN;
          8'd7: cmd.op = jdp_pkg::OP_TILT;
          default: cmd.op = jdp_pkg::OP_NONE;
        endcase
      end
      jdp_pkg::MODE_BUTTON: begin
        if (item.event_number == 8'd2 && item.event_value == 16'sd1)
          cmd.op = jdp_pkg::OP_STOP;
      end
      default: cmd.op = jdp_pkg::OP_NONE;
    endcase
  end
endmodule

// ===== rtl/jdp_queue.sv =====
// short queue of classified requests between front and back
module jdp_queue #(
  parameter int DEPTH = jdp_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  jdp_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output jdp_pkg::cmd_t pop_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  jdp_pkg::cmd_t mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;

  assign full = (count == (AW+1)'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0; rd_ptr <= '0; count <= '0;
    end else begin
      if (push && !full)
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (pop && not_empty)
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(push && !full) - (AW+1)'(pop && not_empty);
    end
  end
endmodule

// ===== rtl/jdp_back.sv =====
// back end: percent divide, speed, heading, brake, camera and output register
module jdp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  jdp_pkg::cmd_t     cmd,
  output logic              cmd_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output jdp_pkg::out_item_t out_item
);
  jdp_pkg::state_t state, state_next;

  logic signed [7:0] x_percent, y_percent;
  logic [6:0]        drive_speed, brake_level;
  logic [8:0]        drive_heading;
  logic signed [7:0] pan_position, tilt_position;

  jdp_pkg::cmd_t     cur;
  logic [16:0]       rem;     // restoring divider remainder
  logic [15:0]       quo;
  logic [4:0]        cnt;
  logic [6:0]        s;       // square root trial
  logic [5:0]        d;       // octant table index
  logic [5:0]        fd;
  logic [6:0]        ax, ay, mn, mx;
  logic [14:0]       sum;
  logic [16:0]       bsum;
  logic              brake_neg;
  logic [22:0]       bprod;
  logic [21:0]       bhalf;
  logic [6:0]        bq0;
  logic [15:0]       bt;
  logic [6:0]        bq_calc;
  logic [6:0]        bq;

  logic [17:0] rtrial;
  logic        div_done;
  logic [7:0]  pct;
  logic [14:0] sq1;
  logic [40:0] lhs;
  logic [40:0] rhs;

  assign rtrial = {rem, quo[15]} - {3'b000, cur.divisor};
  assign div_done = (cnt == 5'd16);
  assign pct = (quo > 16'd100) ? 8'd100 : quo[7:0];
  assign sq1 = (15'(s) + 15'd1) * (15'(s) + 15'd1);
  assign lhs = 41'(mx) * 41'(jdp_pkg::tan_entry(d));
  assign rhs = 41'(mn) * 41'd10000000000;

  // brake: (v + 32767) * 100 / 65534; 65534 = 2 * 32767
  assign bsum = 17'(cur.value) + 17'sd32767;
  assign brake_neg = bsum[16];
  assign bprod = 23'(bsum[15:0]) * 23'd100;
  // divide by 32767: quotient is y >> 15 or one more
  assign bhalf = bprod[22:1];
  assign bq0 = bhalf[21:15];
  assign bt = {1'b0, bhalf[14:0]} + {9'd0, bq0};
  assign bq_calc = (bt >= 16'd32767) ? bq0 + 7'd1 : bq0;

  always_comb begin
    state_next = state;
    case (state)
      jdp_pkg::ST_IDLE: if (cmd_valid) state_next = jdp_pkg::ST_DIV;
      jdp_pkg::ST_DIV: begin
        case (cur.op)
          jdp_pkg::OP_AXIS_X, jdp_pkg::OP_AXIS_Y:
            if (cur.divisor == '0) state_next = jdp_pkg::ST_PCT;
            else if (div_done) state_next = jdp_pkg::ST_PCT;
          jdp_pkg::OP_BRAKE: if (div_done) state_next = jdp_pkg::ST_OUT;
          default: state_next = jdp_pkg::ST_OUT;
        endcase
      end
      jdp_pkg::ST_PCT: state_next = jdp_pkg::ST_SQRT;
      jdp_pkg::ST_SQRT:
        if (s == 7'd100 || sq1 > sum) state_next = jdp_pkg::ST_HEAD;
      jdp_pkg::ST_HEAD:
        state_next = (ax == '0 || ay == '0 || ax == ay) ? jdp_pkg::ST_FIN : jdp_pkg::ST_OCT;
      jdp_pkg::ST_OCT: if (d == 6'd44) state_next = jdp_pkg::ST_FIN;
      jdp_pkg::ST_FIN: state_next = jdp_pkg::ST_OUT;
      jdp_pkg::ST_OUT: if (!out_valid || !out_stall) state_next = jdp_pkg::ST_IDLE;
      default: state_next = jdp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop = (state == jdp_pkg::ST_IDLE) && cmd_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= jdp_pkg::ST_IDLE;
    else state <= state_next;
  end

  logic signed [9:0] kint;
  logic signed [9:0] hsel;
  logic              sx, sy;

  always_comb begin
    sx = x_percent[7];
    sy = y_percent[7];
    if (!sx && !sy) kint = 10'sd0;
    else if (sx && !sy) kint = 10'sd180;
    else if (sx) kint = 10'sd180;
    else kint = 10'sd360;
    begin
      logic signed [9:0] base;
      logic              exact, sa, sq;
      sq = !((sx && !sy) || (!sx && sy));
      exact = 1'b1; sa = 1'b1;
      if (ay == '0) base = 10'sd0;
      else if (ax == '0) base = 10'sd90;
      else if (ax == ay) base = 10'sd45;
      else if (ay < ax) begin base = 10'sd0; exact = 1'b0; end
      else begin base = 10'sd90; sa = 1'b0; exact = 1'b0; end
      if (sq) hsel = kint + base; else hsel = kint - base;
      if (!exact) begin
        if (sq == sa) hsel = hsel + 10'(fd);
        else hsel = hsel - 10'sd1 - 10'(fd);
      end
      if (ax == '0 && ay == '0) hsel = 10'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (state == jdp_pkg::ST_OUT) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_percent <= '0; y_percent <= '0; drive_speed <= '0; drive_heading <= '0;
      brake_level <= '0; pan_position <= '0; tilt_position <= '0;
    end else begin
      case (state)
        jdp_pkg::ST_IDLE: if (cmd_valid) begin
          cur <= cmd;
          rem <= '0;
          cnt <= '0;
          if (cmd.op == jdp_pkg::OP_BRAKE) quo <= '0;
          else quo <= cmd.value[16] ? 16'(-cmd.value) : cmd.value[15:0];
        end
        jdp_pkg::ST_DIV: begin
          case (cur.op)
            jdp_pkg::OP_AXIS_X, jdp_pkg::OP_AXIS_Y: if (!div_done) begin
              if (!rtrial[17]) begin
                rem <= rtrial[16:0]; quo <= {quo[14:0], 1'b1};
              end else begin
                rem <= {rem[15:0], quo[15]}; quo <= {quo[14:0], 1'b0};
              end
              cnt <= cnt + 1'b1;
            end
            jdp_pkg::OP_BRAKE: begin
              bq <= brake_neg ? 7'd0 : bq_calc;
              cnt <= 5'd16;
              if (div_done) brake_level <= bq;
            end
            jdp_pkg::OP_PAN: begin
              if (cur.value[16] && pan_position <= 8'sd85) pan_position <= pan_position + 8'sd5;
              else if (!cur.value[16] && cur.value != '0 && pan_position >= -8'sd85)
                pan_position <= pan_position - 8'sd5;
            end
            jdp_pkg::OP_TILT: begin
              if (cur.value[16] && tilt_position <= 8'sd85) tilt_position <= tilt_position + 8'sd5;
              else if (!cur.value[16] && cur.value != '0 && tilt_position >= -8'sd85)
                tilt_position <= tilt_position - 8'sd5;
            end
            jdp_pkg::OP_STOP: begin drive_speed <= '0; drive_heading <= '0; end
            default: ;
          endcase
        end
        jdp_pkg::ST_PCT: begin
          // quotient sign from value sign and divisor sign
          begin
            logic neg;
            logic signed [7:0] p;
            neg = cur.value[16] ^ cur.div_neg;
            p = (cur.divisor == '0) ? 8'sd0 : (neg ? -$signed(pct) : $signed(pct));
            if (cur.op == jdp_pkg::OP_AXIS_Y) begin
              y_percent <= p;
              ax <= x_percent[7] ? 7'(-x_percent) : x_percent[6:0];
              ay <= p[7] ? 7'(-p) : p[6:0];
              sum <= 15'(x_percent * x_percent) + 15'(p * p);
            end else begin
              x_percent <= p;
              ax <= p[7] ? 7'(-p) : p[6:0];
              ay <= y_percent[7] ? 7'(-y_percent) : y_percent[6:0];
              sum <= 15'(p * p) + 15'(y_percent * y_percent);
            end
          end
          s <= '0;
        end
        jdp_pkg::ST_SQRT: begin
          if (!(s == 7'd100 || sq1 > sum)) s <= s + 1'b1;
          else drive_speed <= s;
          mn <= (ay < ax) ? ay : ax;
          mx <= (ay < ax) ? ax : ay;
          d <= 6'd1;
          fd <= '0;
        end
        jdp_pkg::ST_HEAD: ;
        jdp_pkg::ST_OCT: begin
          if (lhs <= rhs) fd <= d;
          d <= d + 1'b1;
        end
        jdp_pkg::ST_FIN: drive_heading <= hsel[8:0];
        jdp_pkg::ST_OUT: if (!out_valid || !out_stall) begin
          out_item.speed_pct <= drive_speed;
          out_item.heading_deg <= drive_heading;
          out_item.brake_pct <= brake_level;
          out_item.pan_deg <= pan_position;
          out_item.tilt_deg <= tilt_position;
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== bench/tb_top.sv =====
// self-checking bench for the joystick dead-zone polar drive block
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AXIS_FULL = 32767;
  localparam int SETTLE_CYCLES = 400;
  localparam logic [1:0] MODE_OTHER = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [7:0] AXIS_X = 8'd0;
  localparam logic [7:0] AXIS_Y = 8'd1;
  localparam logic [7:0] AXIS_BRAKE = 8'd2;
  localparam logic [7:0] AXIS_PAN = 8'd6;
  localparam logic [7:0] AXIS_TILT = 8'd7;
  localparam logic [7:0] BUTTON_STOP = 8'd2;

  // tan(1..44 deg) times 1e10, rounded
  localparam longint unsigned TAN_E10 [1:44] = '{
    64'd174550649, 64'd349207695, 64'd524077793, 64'd699268119, 64'd874886635,
    64'd1051042353, 64'd1227845609, 64'd1405408347, 64'd1583844403,
    64'd1763269807, 64'd1943803091, 64'd2125565617, 64'd2308681911,
    64'd2493280028, 64'd2679491924, 64'd2867453858, 64'd3057306815,
    64'd3249196962, 64'd3443276133, 64'd3639702343, 64'd3838640350,
    64'd4040262258, 64'd4244748162, 64'd4452286853, 64'd4663076582,
    64'd4877325886, 64'd5095254495, 64'd5317094317, 64'd5543090515,
    64'd5773502692, 64'd6008606190, 64'd6248693519, 64'd6494075932,
    64'd6745085168, 64'd7002075382, 64'd7265425280, 64'd7535540501,
    64'd7812856265, 64'd8097840332, 64'd8390996312, 64'd8692867378,
    64'd9004040443, 64'd9325150861, 64'd9656887748};

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  jdp_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  jdp_pkg::out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [14:0] cfg_data;

  joystick_deadzone_polar_drive dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // predicted drive state
  int dz_width;
  int x_pct, y_pct, pan_pos, tilt_pos;
  int speed_now, heading_now, brake_now;

  jdp_pkg::out_item_t pending_drive[$];
  int requests_taken;
  int dz_writes;
  bit failed;
  bit quiet_phase;
  int stall_left;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int pct_of(int v, int divisor);
    int q;
    if (divisor == 0) return 0;
    q = v / divisor;
    if (q > jdp_pkg::PCT_MAX) q = jdp_pkg::PCT_MAX;
    if (q < -jdp_pkg::PCT_MAX) q = -jdp_pkg::PCT_MAX;
    return q;
  endfunction

  function automatic int root_capped(int x, int y);
    int sum, s;
    sum = x * x + y * y;
    s = 0;
    while (s < jdp_pkg::PCT_MAX && (s + 1) * (s + 1) <= sum) s++;
    return s;
  endfunction

  function automatic int whole_deg(int m, int big);
    int fd;
    fd = 0;
    for (int d = 1; d <= 44; d++)
      if (longint'(big) * TAN_E10[d] <= longint'(m) * 64'd10000000000) fd = d;
    return fd;
  endfunction

  function automatic int heading_from(int x, int y);
    int ax, ay, base, sa, fd, k, sq, kint;
    bit exact;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    sa = 1;
    fd = 0;
    exact = 1'b1;
    if (ax == 0 && ay == 0) return 0;
    if (ay == 0) base = 0;
    else if (ax == 0) base = 90;
    else if (ax == ay) base = 45;
    else if (ay < ax) begin
      base = 0;
      exact = 1'b0;
      fd = whole_deg(ay, ax);
    end else begin
      base = 90;
      sa = -1;
      exact = 1'b0;
      fd = whole_deg(ax, ay);
    end
    if (x >= 0 && y >= 0) begin
      k = 0;
      sq = 1;
    end else if (x < 0 && y >= 0) begin
      k = 180;
      sq = -1;
    end else if (x < 0) begin
      k = 180;
      sq = 1;
    end else begin
      k = 360;
      sq = -1;
    end
    kint = k + sq * base;
    if (exact) return kint;
    return (sq * sa > 0) ? kint + fd : kint - 1 - fd;
  endfunction

  function automatic int camera_step(int pos, int v);
    if (v < 0 && pos + jdp_pkg::CAM_STEP <= jdp_pkg::CAM_LIMIT)
      return pos + jdp_pkg::CAM_STEP;
    if (v > 0 && pos - jdp_pkg::CAM_STEP >= -jdp_pkg::CAM_LIMIT)
      return pos - jdp_pkg::CAM_STEP;
    return pos;
  endfunction

  function automatic jdp_pkg::out_item_t apply_event(jdp_pkg::in_item_t e);
    int v, s;
    jdp_pkg::out_item_t r;
    v = int'(e.event_value);
    if (e.mode == jdp_pkg::MODE_AXIS) begin
      if (e.event_number == AXIS_X || e.event_number == AXIS_Y) begin
        if (v <= dz_width && v >= -dz_width) v = 0;
        else if (v > dz_width) v -= dz_width;
        else v += dz_width;
        if (e.event_number == AXIS_Y) y_pct = pct_of(v, (dz_width - AXIS_FULL) / 100);
        else x_pct = pct_of(v, (AXIS_FULL - dz_width) / 100);
        speed_now = root_capped(x_pct, y_pct);
        heading_now = heading_from(x_pct, y_pct);
      end else if (e.event_number == AXIS_BRAKE) begin
        s = v + 32767;
        brake_now = s < 0 ? 0 : s * jdp_pkg::PCT_MAX / 65534;
      end else if (e.event_number == AXIS_PAN) begin
        pan_pos = camera_step(pan_pos, v);
      end else if (e.event_number == AXIS_TILT) begin
        tilt_pos = camera_step(tilt_pos, v);
      end
    end else if (e.mode == jdp_pkg::MODE_BUTTON) begin
      if (e.event_number == BUTTON_STOP && v == 1) begin
        speed_now = 0;
        heading_now = 0;
      end
    end
    r.speed_pct = speed_now[6:0];
    r.heading_deg = heading_now[8:0];
    r.brake_pct = brake_now[6:0];
    r.pan_deg = pan_pos[7:0];
    r.tilt_deg = tilt_pos[7:0];
    return r;
  endfunction

  // prediction on every accepted request and register write
  always @(posedge clk) begin
    if (rst) begin
      dz_width = 0;
      x_pct = 0;
      y_pct = 0;
      pan_pos = 0;
      tilt_pos = 0;
      speed_now = 0;
      heading_now = 0;
      brake_now = 0;
    end else begin
      if (in_valid && !in_stall) begin
        pending_drive.push_back(apply_event(in_data));
        requests_taken <= requests_taken + 1;
      end
      if (cfg_valid && cfg_ready) begin
        dz_width = int'(cfg_data);
        dz_writes <= dz_writes + 1;
      end
    end
  end

  // result checking
  always @(posedge clk) begin
    jdp_pkg::out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_drive.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        failed = 1'b1;
      end else begin
        want = pending_drive.pop_front();
        if (out_data.speed_pct !== want.speed_pct) begin
          $display("%0t: speed expected %0d actual %0d", $time, want.speed_pct,
                   out_data.speed_pct);
          failed = 1'b1;
        end
        if (out_data.heading_deg !== want.heading_deg) begin
          $display("%0t: heading expected %0d actual %0d", $time, want.heading_deg,
                   out_data.heading_deg);
          failed = 1'b1;
        end
        if (out_data.brake_pct !== want.brake_pct) begin
          $display("%0t: brake expected %0d actual %0d", $time, want.brake_pct,
                   out_data.brake_pct);
          failed = 1'b1;
        end
        if (out_data.pan_deg !== want.pan_deg) begin
          $display("%0t: pan expected %0d actual %0d", $time, want.pan_deg,
                   out_data.pan_deg);
          failed = 1'b1;
        end
        if (out_data.tilt_deg !== want.tilt_deg) begin
          $display("%0t: tilt expected %0d actual %0d", $time, want.tilt_deg,
                   out_data.tilt_deg);
          failed = 1'b1;
        end
      end
    end
  end

  function automatic int gap_len();
    if (quiet_phase) return 0;
    return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 40);
  endfunction

  // result back-pressure, with stretches of none
  always @(negedge clk) begin
    if (rst || quiet_phase) begin
      out_stall = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      out_stall = ($urandom_range(0, 2) == 0);
      stall_left = out_stall ? gap_len() : $urandom_range(0, 6);
    end
  end

  task automatic send_event(logic [1:0] mode, logic [7:0] num, logic signed [15:0] val);
    int gap, target;
    jdp_pkg::in_item_t e;
    gap = gap_len();
    e.mode = mode;
    e.event_number = num;
    e.event_value = val;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = e;
    target = requests_taken + 1;
    do @(negedge clk); while (requests_taken != target);
  endtask

  task automatic drain_and_set(logic [14:0] width);
    int target;
    in_valid = 1'b0;
    wait (pending_drive.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = width;
    target = dz_writes + 1;
    do @(negedge clk); while (dz_writes != target);
    cfg_valid = 1'b0;
  endtask

  task automatic test_directed();
    quiet_phase = 1'b0;
    drain_and_set(15'd0);
    send_event(jdp_pkg::MODE_AXIS, AXIS_X, 16'sd32767);
    send_event(jdp_pkg::MODE_AXIS, AXIS_Y, -16'sd32768);
    send_event(jdp_pkg::MODE_AXIS, AXIS_X, -16'sd32768);
    send_event(jdp_pkg::MODE_AXIS, AXIS_Y, 16'sd32767);
    send_event(jdp_pkg::MODE_AXIS, AXIS_X, 16'sd9000);
    send_event(jdp_pkg::MODE_AXIS, AXIS_X, 16'sd0);
    send_event(jdp_pkg::MODE_AXIS, AXIS_Y, 16'sd0);
    send_event(jdp_pkg::MODE_AXIS, AXIS_BRAKE, -16'sd32768);
    send_event(jdp_pkg::MODE_AXIS, AXIS_BRAKE, 16'sd32767);
    send_event(jdp_pkg::MODE_AXIS, AXIS_BRAKE, 16'sd0);
    send_event(jdp_pkg::MODE_AXIS, AXIS_PAN, -16'sd1);
    send_event(jdp_pkg::MODE_AXIS, AXIS_TILT, 16'sd1);
    send_event(jdp_pkg::MODE_AXIS, AXIS_PAN, 16'sd0);
    send_event(jdp_pkg::MODE_AXIS, AXIS_X, 16'sd20000);
    send_event(jdp_pkg::MODE_BUTTON, BUTTON_STOP, 16'sd0);
    send_event(jdp_pkg::MODE_BUTTON, BUTTON_STOP, 16'sd1);
    send_event(jdp_pkg::MODE_BUTTON, 8'd5, 16'sd1);
    send_event(MODE_OTHER, AXIS_X, 16'sd100);
    send_event(MODE_SPARE, AXIS_PAN, -16'sd5);
    send_event(jdp_pkg::MODE_AXIS, 8'd255, 16'sd77);
    // dead zone edge is inside the zone
    drain_and_set(15'd1000);
    send_event(jdp_pkg::MODE_AXIS, AXIS_X, 16'sd1000);
    send_event(jdp_pkg::MODE_AXIS, AXIS_Y, -16'sd1000);
    send_event(jdp_pkg::MODE_AXIS, AXIS_X, 16'sd1001);
    send_event(jdp_pkg::MODE_AXIS, AXIS_Y, -16'sd1330);
  endtask

  task automatic random_events(int count);
    logic [1:0] mode;
    logic [7:0] num;
    logic signed [15:0] val;
    int pick;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 50) quiet_phase = ~quiet_phase;
      pick = $urandom_range(0, 99);
      mode = jdp_pkg::MODE_AXIS;
      if (pick < 35) num = 8'($urandom_range(0, 1));
      else if (pick < 45) num = AXIS_BRAKE;
      else if (pick < 65) num = $urandom_range(0, 1) ? AXIS_PAN : AXIS_TILT;
      else if (pick < 80) begin
        mode = jdp_pkg::MODE_BUTTON;
        num = $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255)) : BUTTON_STOP;
      end else if (pick < 88) begin
        mode = 2'($urandom_range(2, 3));
        num = 8'($urandom_range(0, 255));
      end else num = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 7))
        0: val = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        1: val = 16'(int'($urandom_range(0, 2)) - 1);
        2: val = $urandom_range(0, 1) ? 16'(dz_width + int'($urandom_range(0, 2)) - 1)
                                      : 16'(-dz_width + int'($urandom_range(0, 2)) - 1);
        default: val = 16'($urandom);
      endcase
      send_event(mode, num, val);
    end
  endtask

  task automatic test_dead_zones();
    logic [14:0] widths [6];
    widths = '{15'd0, 15'd32767, 15'd30000, 15'd32667, 15'd3000, 15'd0};
    foreach (widths[i]) begin
      drain_and_set(widths[i]);
      random_events(100);
    end
    drain_and_set(15'($urandom_range(1, 30000)));
    random_events(220);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    requests_taken = 0;
    dz_writes = 0;
    failed = 1'b0;
    quiet_phase = 1'b0;
    stall_left = 0;
    repeat (5) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_dead_zones();
    in_valid = 1'b0;
    wait (pending_drive.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (failed || pending_drive.size() != 0) begin
      $display("FAILURE");
    end else begin
      $display("SUCCESS");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end
endmodule
